// ----- hdl/rau_pkg.sv -----
// Shared definitions for the rational arithmetic unit.
// Holds widths, operation and order codes, and the controller/datapath interface structs.
// No dependencies; every other file in the block refers to this package by scoped names.
package rau_pkg;

  // Operand and result widths and the widths that follow from them.
  localparam int OPERAND_WIDTH = 16;
  localparam int RESULT_WIDTH  = 34;
  localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int EXT_WIDTH     = (PROD_WIDTH + 2 > RESULT_WIDTH) ? PROD_WIDTH + 2 : RESULT_WIDTH;
  localparam int SHIFT_WIDTH   = $clog2(OPERAND_WIDTH);

  // Operation kinds carried by an input word.
  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4,
    KIND_RED = 3'd5
  } kind_t;

  // Three-way order codes of compare.
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Product selections for the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P_ANBD,
    MUL_P_ANBN,
    MUL_Q_BNAD,
    MUL_D_ADBD,
    MUL_D_ADBN
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    gcd_run;
    logic    div_init;
    logic    div_run;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  red_trivial;
    logic  gcd_done;
    logic  div_last;
  } sts_t;

endpackage

// ----- hdl/rau_dp.sv -----
// Datapath of the rational arithmetic unit: operand registers, shared multiplier,
// binary gcd, two-lane restoring divider and the output word registers.
// Depends on rau_pkg for widths, codes and the command/status structs.
module rau_dp (
  input  logic                               clk,
  input  rau_pkg::cmd_t                      cmd,
  output rau_pkg::sts_t                      sts,
  input  logic [2:0]                         in_kind,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_a_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_a_denominator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_b_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_b_denominator,
  output logic signed [rau_pkg::RESULT_WIDTH-1:0]  out_result_numerator,
  output logic signed [rau_pkg::RESULT_WIDTH-1:0]  out_result_denominator,
  output logic [1:0]                         out_order,
  output logic                               out_zero_denominator
);

  localparam int OW = rau_pkg::OPERAND_WIDTH;
  localparam int PW = rau_pkg::PROD_WIDTH;
  localparam int EW = rau_pkg::EXT_WIDTH;
  localparam int RW = rau_pkg::RESULT_WIDTH;
  localparam int KW = rau_pkg::SHIFT_WIDTH;

  // Captured operands.
  rau_pkg::kind_t         kind_r;
  logic signed [OW-1:0]   an_r, ad_r, bn_r, bd_r;

  // Products.
  logic signed [OW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   p_r, q_r, d_r;

  // Gcd and divider state.
  logic [OW-1:0]          mag_n, mag_d;
  logic [OW-1:0]          u_r, u_nxt, v_r, v_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [OW-1:0]          gdiv_r;
  logic [OW-1:0]          nq_r, nq_nxt, dq_r, dq_nxt;
  logic [OW-1:0]          nrem_r, nrem_nxt, drem_r, drem_nxt;
  logic [OW:0]            ntrial, dtrial;
  logic                   nge, dge;
  logic [KW-1:0]          cnt_r;

  // Result composition.
  logic signed [EW-1:0]   p_ext, q_ext, d_ext, sum_ext, an_ext, nq_ext;
  logic signed [EW-1:0]   rn_ext, rd_ext;
  logic [1:0]             ord;
  logic                   zf;

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= rau_pkg::kind_t'(in_kind);
      an_r   <= in_a_numerator;
      ad_r   <= in_a_denominator;
      bn_r   <= in_b_numerator;
      bd_r   <= in_b_denominator;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (cmd.mul_op)
      rau_pkg::MUL_P_ANBD: begin mul_a = an_r; mul_b = bd_r; end
      rau_pkg::MUL_P_ANBN: begin mul_a = an_r; mul_b = bn_r; end
      rau_pkg::MUL_Q_BNAD: begin mul_a = bn_r; mul_b = ad_r; end
      rau_pkg::MUL_D_ADBD: begin mul_a = ad_r; mul_b = bd_r; end
      rau_pkg::MUL_D_ADBN: begin mul_a = ad_r; mul_b = bn_r; end
      default: begin mul_a = an_r; mul_b = bd_r; end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Product registers, one written per multiply cycle.
  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      rau_pkg::MUL_P_ANBD, rau_pkg::MUL_P_ANBN: p_r <= prod;
      rau_pkg::MUL_Q_BNAD: q_r <= prod;
      rau_pkg::MUL_D_ADBD, rau_pkg::MUL_D_ADBN: d_r <= prod;
      default: ;
    endcase
  end

  // Magnitudes of the first fraction; the most negative value maps to its unsigned magnitude.
  assign mag_n = an_r[OW-1] ? (~an_r + OW'(1)) : an_r;
  assign mag_d = ad_r[OW-1] ? (~ad_r + OW'(1)) : ad_r;

  // One binary gcd step: strip common twos, strip lone twos, or subtract odd values.
  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    k_nxt = k_r;
    if (!u_r[0] && !v_r[0]) begin
      u_nxt = u_r >> 1;
      v_nxt = v_r >> 1;
      k_nxt = k_r + KW'(1);
    end else if (!u_r[0]) begin
      u_nxt = u_r >> 1;
    end else if (!v_r[0]) begin
      v_nxt = v_r >> 1;
    end else if (u_r > v_r) begin
      u_nxt = u_r - v_r;
    end else begin
      v_nxt = v_r - u_r;
    end
  end

  // The gcd registers load from the operands whenever no gcd step runs.
  always_ff @(posedge clk) begin
    if (cmd.gcd_run) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
    end else begin
      u_r <= mag_n;
      v_r <= mag_d;
      k_r <= '0;
    end
  end

  // Restoring division step for both lanes against the same divisor.
  always_comb begin
    ntrial   = {nrem_r, nq_r[OW-1]};
    dtrial   = {drem_r, dq_r[OW-1]};
    nge      = ntrial >= {1'b0, gdiv_r};
    dge      = dtrial >= {1'b0, gdiv_r};
    nrem_nxt = nge ? OW'(ntrial - {1'b0, gdiv_r}) : ntrial[OW-1:0];
    drem_nxt = dge ? OW'(dtrial - {1'b0, gdiv_r}) : dtrial[OW-1:0];
    nq_nxt   = {nq_r[OW-2:0], nge};
    dq_nxt   = {dq_r[OW-2:0], dge};
  end

  // Divider registers: dividends shift out while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      gdiv_r <= u_r << k_r;
      nq_r   <= mag_n;
      dq_r   <= mag_d;
      nrem_r <= '0;
      drem_r <= '0;
      cnt_r  <= KW'(OW - 1);
    end else if (cmd.div_run) begin
      nq_r   <= nq_nxt;
      dq_r   <= dq_nxt;
      nrem_r <= nrem_nxt;
      drem_r <= drem_nxt;
      cnt_r  <= cnt_r - KW'(1);
    end
  end

  // Status toward the controller.
  assign sts.kind        = kind_r;
  assign sts.red_trivial = (an_r == '0) || (ad_r == '0);
  assign sts.gcd_done    = (u_r == v_r);
  assign sts.div_last    = (cnt_r == '0);

  // Sign and zero extensions to the composition width.
  assign p_ext   = {{(EW-PW){p_r[PW-1]}}, p_r};
  assign q_ext   = {{(EW-PW){q_r[PW-1]}}, q_r};
  assign d_ext   = {{(EW-PW){d_r[PW-1]}}, d_r};
  assign an_ext  = {{(EW-OW){an_r[OW-1]}}, an_r};
  assign nq_ext  = {{(EW-OW){1'b0}}, nq_r};
  assign sum_ext = (kind_r == rau_pkg::KIND_SUB) ? (p_ext - q_ext) : (p_ext + q_ext);

  // Result composition per operation kind.
  always_comb begin
    rn_ext = '0;
    rd_ext = '0;
    ord    = rau_pkg::ORD_LESS;
    zf     = 1'b0;
    case (kind_r)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        rn_ext = sum_ext;
        rd_ext = d_ext;
        zf     = (d_r == '0);
      end
      rau_pkg::KIND_MUL, rau_pkg::KIND_DIV: begin
        rn_ext = p_ext;
        rd_ext = d_ext;
        zf     = (d_r == '0);
      end
      rau_pkg::KIND_CMP: begin
        if (p_r < q_r) begin
          ord = rau_pkg::ORD_LESS;
        end else if (p_r == q_r) begin
          ord = rau_pkg::ORD_EQUAL;
        end else begin
          ord = rau_pkg::ORD_GREATER;
        end
      end
      rau_pkg::KIND_RED: begin
        if (ad_r == '0) begin
          // A zero denominator passes the numerator through and raises the flag.
          rn_ext = an_ext;
          zf     = 1'b1;
        end else if (an_r == '0) begin
          // Zero reduces to zero over one.
          rd_ext = EW'(1);
        end else begin
          rn_ext = (an_r[OW-1] != ad_r[OW-1]) ? (EW'(0) - nq_ext) : nq_ext;
          rd_ext = {{(EW-OW){1'b0}}, dq_r};
        end
      end
      default: ;
    endcase
  end

  // Output word registers.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_result_numerator   <= rn_ext[RW-1:0];
      out_result_denominator <= rd_ext[RW-1:0];
      out_order              <= ord;
      out_zero_denominator   <= zf;
    end
  end

endmodule

// ----- hdl/rau_ctrl.sv -----
// Controller of the rational arithmetic unit: sequences multiply, gcd and divide steps.
// Depends on rau_pkg for kind codes and the command/status structs.
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::cmd_t cmd,
  input  rau_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_GCD,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Commands and next state.
  always_comb begin
    cmd           = '0;
    cmd.mul_op    = rau_pkg::MUL_NONE;
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in  = 1'b1;
          in_stall_nxt = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.kind inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB, rau_pkg::KIND_MUL,
                             rau_pkg::KIND_DIV, rau_pkg::KIND_CMP}) begin
          state_nxt = S_MUL0;
        end else if (sts.kind == rau_pkg::KIND_RED && !sts.red_trivial) begin
          state_nxt = S_GCD;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MUL0: begin
        cmd.mul_op = (sts.kind == rau_pkg::KIND_MUL) ? rau_pkg::MUL_P_ANBN
                                                     : rau_pkg::MUL_P_ANBD;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        case (sts.kind)
          rau_pkg::KIND_MUL: cmd.mul_op = rau_pkg::MUL_D_ADBD;
          rau_pkg::KIND_DIV: cmd.mul_op = rau_pkg::MUL_D_ADBN;
          default:           cmd.mul_op = rau_pkg::MUL_Q_BNAD;
        endcase
        state_nxt = (sts.kind inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB}) ? S_MUL2 : S_FINISH;
      end
      S_MUL2: begin
        cmd.mul_op = rau_pkg::MUL_D_ADBD;
        state_nxt  = S_FINISH;
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_run = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result word is written once the output register is free or being taken.
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted word always moves the controller into decode.
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted word did not enter decode");

  // A result word is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result written while output register busy");

  // The input side is held off for the whole time an item is in work.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  // The divider runs its full count before the result is composed.
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !sts.div_last) |=> (state_r == S_DIV))
    else $error("divider left early");

endmodule

// ----- hdl/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit: joins the controller and the datapath.
// Depends on rau_pkg, rau_ctrl and rau_dp.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   kind, a/b numerator and denominator
//   out      output     out_valid/out_stall result numerator/denominator, order, zero flag
//
// Add and subtract form three products through a shared multiplier at one product per
// cycle; multiply, divide and compare form two. Reduce runs the binary gcd and then the
// divider, which resolves one quotient bit of both lanes per cycle; a trivial reduce and
// the unused kinds go straight to the result write. Words are worked one at a time.
// Reset is synchronous and active low and clears only the controller. A waiting result holds
// in the output register while the next word is worked; only its write waits for the taker.
module rational_arithmetic_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         in_kind,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_a_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_a_denominator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_b_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_b_denominator,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rau_pkg::RESULT_WIDTH-1:0]  out_result_numerator,
  output logic signed [rau_pkg::RESULT_WIDTH-1:0]  out_result_denominator,
  output logic [1:0]                         out_order,
  output logic                               out_zero_denominator
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and result registers.
  rau_dp u_dp (
    .clk                    (clk),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_kind                (in_kind),
    .in_a_numerator         (in_a_numerator),
    .in_a_denominator       (in_a_denominator),
    .in_b_numerator         (in_b_numerator),
    .in_b_denominator       (in_b_denominator),
    .out_result_numerator   (out_result_numerator),
    .out_result_denominator (out_result_denominator),
    .out_order              (out_order),
    .out_zero_denominator   (out_zero_denominator)
  );

endmodule

// ----- bench/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the rational arithmetic unit: predicts each result word
// from the operand word and checks every output word in order. Depends on rau_pkg.
module rational_arithmetic_unit_tb;

  localparam int OW            = rau_pkg::OPERAND_WIDTH;
  localparam int RW            = rau_pkg::RESULT_WIDTH;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 200;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_GAP       = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam longint NEGATE_FACTOR = -1;

  // Codes that the kind port allows but the block does not define.
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]           kind;
    logic signed [OW-1:0] an;
    logic signed [OW-1:0] ad;
    logic signed [OW-1:0] bn;
    logic signed [OW-1:0] bd;
  } operand_word_t;

  typedef struct packed {
    logic [RW-1:0] num;
    logic [RW-1:0] den;
    logic [1:0]    ord;
    logic          zf;
  } fraction_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_kind;
  logic signed [OW-1:0] in_a_numerator;
  logic signed [OW-1:0] in_a_denominator;
  logic signed [OW-1:0] in_b_numerator;
  logic signed [OW-1:0] in_b_denominator;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RW-1:0] out_result_numerator;
  logic signed [RW-1:0] out_result_denominator;
  logic [1:0] out_order;
  logic out_zero_denominator;

  fraction_result_t pending_results[$];
  int error_count   = 0;
  int checked_count = 0;
  int sent_count    = 0;
  int kind_count[8];
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  rational_arithmetic_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_kind),
    .in_a_numerator         (in_a_numerator),
    .in_a_denominator       (in_a_denominator),
    .in_b_numerator         (in_b_numerator),
    .in_b_denominator       (in_b_denominator),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_result_numerator   (out_result_numerator),
    .out_result_denominator (out_result_denominator),
    .out_order              (out_order),
    .out_zero_denominator   (out_zero_denominator)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, pending_results.size());
      $display("** rational_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  // Exact fraction arithmetic, wrapped to the result width at the end.
  function automatic fraction_result_t predict_fraction(operand_word_t w);
    fraction_result_t r;
    longint an, ad, bn, bd, p, q, d, mn, md, g, y, t, n;
    r  = '0;
    an = w.an;
    ad = w.ad;
    bn = w.bn;
    bd = w.bd;
    case (w.kind)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        d = ad * bd;
        p = an * bd;
        q = bn * ad;
        r.num = (w.kind == rau_pkg::KIND_ADD) ? RW'(p + q) : RW'(p - q);
        r.den = RW'(d);
        r.zf  = (d == 0);
      end
      rau_pkg::KIND_MUL: begin
        d = ad * bd;
        r.num = RW'(an * bn);
        r.den = RW'(d);
        r.zf  = (d == 0);
      end
      rau_pkg::KIND_DIV: begin
        d = ad * bn;
        r.num = RW'(an * bd);
        r.den = RW'(d);
        r.zf  = (d == 0);
      end
      rau_pkg::KIND_CMP: begin
        // Raw cross products; denominator signs are not corrected.
        p = an * bd;
        q = bn * ad;
        r.ord = (p < q) ? rau_pkg::ORD_LESS
                        : ((p == q) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
      end
      rau_pkg::KIND_RED: begin
        if (ad == 0) begin
          r.num = RW'(an);
          r.den = '0;
          r.zf  = 1'b1;
        end else if (an == 0) begin
          r.den = RW'(1);
        end else begin
          mn = (an < 0) ? -an : an;
          md = (ad < 0) ? -ad : ad;
          g  = mn;
          y  = md;
          while (y != 0) begin
            t = g % y;
            g = y;
            y = t;
          end
          n = mn / g;
          if ((an < 0) != (ad < 0)) n = n * NEGATE_FACTOR;
          r.num = RW'(n);
          r.den = RW'(md / g);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Result checker: every accepted output word against the oldest prediction.
  always @(posedge clk) begin
    fraction_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected result word %0d/%0d order %0d zero %0b", $time,
                   out_result_numerator, out_result_denominator, out_order,
                   out_zero_denominator);
      end else begin
        want = pending_results.pop_front();
        if (out_result_numerator !== want.num) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: numerator mismatch, expected %0d actual %0d", $time,
                     $signed(want.num), out_result_numerator);
        end
        if (out_result_denominator !== want.den) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: denominator mismatch, expected %0d actual %0d", $time,
                     $signed(want.den), out_result_denominator);
        end
        if (out_order !== want.ord) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: order mismatch, expected %0d actual %0d", $time,
                     want.ord, out_order);
        end
        if (out_zero_denominator !== want.zf) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: zero flag mismatch, expected %0b actual %0b", $time,
                     want.zf, out_zero_denominator);
        end
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int idle_gap();
    int g;
    g = 0;
    while (g < MAX_GAP && $urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  // Offer one word after an optional idle gap and hold it until it is taken.
  task automatic send_word(operand_word_t w);
    int gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_kind          <= w.kind;
    in_a_numerator   <= w.an;
    in_a_denominator <= w.ad;
    in_b_numerator   <= w.bn;
    in_b_denominator <= w.bd;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_fraction(w));
    sent_count++;
    kind_count[w.kind]++;
  endtask

  task automatic send_fields(logic [2:0] kind, int an, int ad, int bn, int bd);
    operand_word_t w;
    w.kind = kind;
    w.an   = OW'(an);
    w.ad   = OW'(ad);
    w.bn   = OW'(bn);
    w.bd   = OW'(bd);
    send_word(w);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OW-1:0] rand_operand();
    int v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = int'($urandom_range(24)) - 12;
      default: v = $urandom();
    endcase
    return v[OW-1:0];
  endfunction

  function automatic operand_word_t make_random_word();
    operand_word_t w;
    int g, x, y, k;
    w.an = rand_operand();
    w.ad = rand_operand();
    w.bn = rand_operand();
    w.bd = rand_operand();
    if ($urandom_range(19) == 0) w.kind = 3'($urandom_range(7, 6));
    else w.kind = 3'($urandom_range(5));
    // Reduce: build operands with a sizable common factor.
    if (w.kind == rau_pkg::KIND_RED && $urandom_range(2) == 0) begin
      g = $urandom_range(200, 1);
      x = int'($urandom_range(160)) - 80;
      y = int'($urandom_range(160)) - 80;
      w.an = OW'(g * x);
      w.ad = OW'(g * y);
    end
    // Compare: scale a into b so equal cross products come up often.
    if (w.kind == rau_pkg::KIND_CMP && $urandom_range(3) == 0) begin
      x = int'($urandom_range(200)) - 100;
      y = int'($urandom_range(200)) - 100;
      k = int'($urandom_range(20)) - 10;
      w.an = OW'(x);
      w.ad = OW'(y);
      w.bn = OW'(x * k);
      w.bd = OW'(y * k);
    end
    return w;
  endfunction

  // Extremes of every operand through the four arithmetic kinds.
  task automatic test_arith_extremes();
    send_fields(rau_pkg::KIND_ADD, 32767, 32767, 32767, 32767);
    send_fields(rau_pkg::KIND_ADD, -32768, -32768, -32768, -32768);
    send_fields(rau_pkg::KIND_SUB, -32768, 32767, 32767, -32768);
    send_fields(rau_pkg::KIND_SUB, 32767, -32768, -32768, 32767);
    send_fields(rau_pkg::KIND_MUL, -32768, -32768, -32768, -32768);
    send_fields(rau_pkg::KIND_MUL, 32767, -1, -32768, 1);
    send_fields(rau_pkg::KIND_DIV, -32768, 32767, -32768, 32767);
    send_fields(rau_pkg::KIND_DIV, 5, 3, 0, 7);
    send_fields(rau_pkg::KIND_ADD, 1, 0, 2, 3);
    drain_results();
  endtask

  // Compare orders, including negative and zero denominators.
  task automatic test_compare_cases();
    send_fields(rau_pkg::KIND_CMP, 1, 2, 2, 4);
    send_fields(rau_pkg::KIND_CMP, 1, 3, 1, 2);
    send_fields(rau_pkg::KIND_CMP, 3, 4, 1, 2);
    send_fields(rau_pkg::KIND_CMP, 1, -2, 1, 3);
    send_fields(rau_pkg::KIND_CMP, -32768, 32767, 32767, -32768);
    send_fields(rau_pkg::KIND_CMP, 5, 0, 7, 0);
    drain_results();
  endtask

  // Reduce: signs, zero, zero denominator and the most negative value.
  task automatic test_reduce_cases();
    send_fields(rau_pkg::KIND_RED, -6, 4, 9, 9);
    send_fields(rau_pkg::KIND_RED, 6, -4, 0, 0);
    send_fields(rau_pkg::KIND_RED, -6, -4, 0, 0);
    send_fields(rau_pkg::KIND_RED, 0, 5, 0, 0);
    send_fields(rau_pkg::KIND_RED, 7, 0, 0, 0);
    send_fields(rau_pkg::KIND_RED, -32768, -32768, 0, 0);
    send_fields(rau_pkg::KIND_RED, -32768, 1, 0, 0);
    send_fields(rau_pkg::KIND_RED, 32767, -32768, 0, 0);
    drain_results();
  endtask

  // The two codes beyond reduce answer with an all-zero word.
  task automatic test_unused_kinds();
    send_fields(KIND_SPARE_6, 3, 4, 5, 6);
    send_fields(KIND_SPARE_7, -1, -1, -1, -1);
    drain_results();
  endtask

  task automatic test_random_phase(int count, int sender_idle, int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (count) send_word(make_random_word());
    drain_results();
  endtask

  // Long output hold-off while words keep coming, so the input side backs up.
  task automatic test_output_holdoff();
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (40) send_word(make_random_word());
    drain_results();
  endtask

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = '0;
    in_a_numerator   = '0;
    in_a_denominator = '0;
    in_b_numerator   = '0;
    in_b_denominator = '0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_arith_extremes();
    test_compare_cases();
    test_reduce_cases();
    test_unused_kinds();
    test_random_phase(120, 0, 0);
    test_random_phase(100, 85, 0);
    test_random_phase(100, 0, 85);
    test_random_phase(100, 32, 32);
    test_output_holdoff();
    test_random_phase(60, 50, 50);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d predicted results never arrived", $time, pending_results.size());
    end

    $display("Sent %0d words (add %0d, sub %0d, mul %0d, div %0d, cmp %0d, reduce %0d,",
             sent_count, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5]);
    $display("  spare %0d) and checked %0d results under idle, stall and hold-off mixes.",
             kind_count[6] + kind_count[7], checked_count);
    if (error_count == 0) begin
      $display("** rational_arithmetic_unit: PASSED **");
    end else begin
      $display("** rational_arithmetic_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rau_dp.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
